// ===== rtl/core/uvtd_pkg.sv =====
// Shared constants and types for the UV texel density mean block.
// Used by the engine and by the top level; depends on nothing else.
package uvtd_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int SCALE_W = 16;
  localparam int DENSITY_W = 32;
  localparam int OUT_COUNT_W = 32;
  localparam int SKIP_W = 2;
  localparam int CORNER_W = 2;
  localparam int COORD_FRAC = 16;
  localparam int NEAR_ZERO_DIV = 10000000;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CFG_DATA_W-1:0] IMAGE_SIZE_RESET = 16'd1024;

  localparam logic [CORNER_W-1:0] CORNER_FIRST = 2'd0;
  localparam logic [CORNER_W-1:0] CORNER_SECOND = 2'd1;
  localparam logic [CORNER_W-1:0] CORNER_THIRD = 2'd2;
  localparam logic [CORNER_W-1:0] CORNER_NONE = 2'd3;

  typedef struct packed {
    logic start;
    logic clear;
  } eng_ctrl_t;

  typedef struct packed {
    logic done;
    logic skipped;
  } eng_stat_t;

endpackage

// ===== rtl/core/uvtd_alu.sv =====
// Shared adder and subtractor of the density engine.
// Stand-alone; the carry out of a subtraction means a >= b.
module uvtd_alu #(
  parameter int WIDTH = 98
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic             sub,
  output logic [WIDTH-1:0] y,
  output logic             co
);

  logic [WIDTH-1:0] b_eff;

  assign b_eff = sub ? ~b : b;
  assign {co, y} = {1'b0, a} + {1'b0, b_eff} + (WIDTH+1)'(sub);

endmodule

// ===== rtl/core/uvtd_engine.sv =====
// Edge engine: squared lengths by shift and add, two square roots, the ratio
// division and the running mean update, all through one shared uvtd_alu.
// Depends on uvtd_pkg and uvtd_alu.
module uvtd_engine #(
  parameter int COORD_WIDTH = 32,
  parameter int TEX_WIDTH = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  uvtd_pkg::eng_ctrl_t                 ctrl,
  output uvtd_pkg::eng_stat_t                 stat,
  input  logic [2:0][COORD_WIDTH-1:0]         pos_a,
  input  logic [2:0][COORD_WIDTH-1:0]         pos_b,
  input  logic [1:0][TEX_WIDTH-1:0]           tex_a,
  input  logic [1:0][TEX_WIDTH-1:0]           tex_b,
  input  logic [uvtd_pkg::SCALE_W-1:0]        scale_u,
  input  logic [uvtd_pkg::SCALE_W-1:0]        scale_v,
  output logic [uvtd_pkg::DENSITY_W-1:0]      mean,
  output logic [COUNT_WIDTH-1:0]              count
);

  localparam int PIX_W = TEX_WIDTH + uvtd_pkg::SCALE_W;
  localparam int MAX_W = (COORD_WIDTH > PIX_W) ? COORD_WIDTH : PIX_W;
  localparam int ACC_W = 2 * MAX_W + 2;
  localparam int ROOT_STEPS = MAX_W + 1;
  localparam int RATIO_STEPS = COORD_WIDTH + 1 + TEX_WIDTH;
  localparam int MEAN_STEPS = uvtd_pkg::DENSITY_W;
  localparam int STEP_A = (RATIO_STEPS > ROOT_STEPS) ? RATIO_STEPS : ROOT_STEPS;
  localparam int STEP_MAX = (STEP_A > MEAN_STEPS) ? STEP_A : MEAN_STEPS;
  localparam int STEP_W = $clog2(STEP_MAX + 1);
  localparam int LEN3_W = COORD_WIDTH + 1;
  localparam int LEN2_W = PIX_W + 1;
  localparam int DW = uvtd_pkg::DENSITY_W;
  localparam int NEAR3 = (1 << uvtd_pkg::COORD_FRAC) / uvtd_pkg::NEAR_ZERO_DIV;
  localparam int NEAR2 = (1 << TEX_WIDTH) / uvtd_pkg::NEAR_ZERO_DIV;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ABS   = 4'd1;
  localparam logic [3:0] S_ABSN  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_ROOT  = 4'd4;
  localparam logic [3:0] S_CHECK = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_DIFF  = 4'd7;
  localparam logic [3:0] S_DIFFN = 4'd8;
  localparam logic [3:0] S_MEAN  = 4'd9;

  logic [3:0]            state;
  logic [2:0]            k;
  logic [ACC_W-1:0]      acc;
  logic [ACC_W-1:0]      mcand;
  logic [MAX_W-1:0]      mplier;
  logic [MAX_W-1:0]      tmp;
  logic                  mul_tmp;
  logic [ACC_W-1:0]      rem;
  logic [ROOT_STEPS-1:0] root;
  logic [LEN3_W-1:0]     len3;
  logic [LEN2_W-1:0]     len2;
  logic [DW-1:0]         q;
  logic                  ovf;
  logic [DW-1:0]         ratio;
  logic                  up;
  logic                  div_mean;
  logic [STEP_W-1:0]     steps;
  logic                  done;
  logic                  skip_flag;

  logic [ACC_W-1:0]      opx;
  logic [ACC_W-1:0]      opy;
  logic [uvtd_pkg::SCALE_W-1:0] scale_sel;
  logic [ACC_W-1:0]      rem_sh;
  logic [ACC_W-1:0]      div_sh;
  logic [ACC_W-1:0]      trial;
  logic [ROOT_STEPS-1:0] root_step;
  logic [DW-1:0]         q_step;
  logic                  ovf_step;
  logic [ACC_W-1:0]      alu_a;
  logic [ACC_W-1:0]      alu_b;
  logic                  alu_sub;
  logic [ACC_W-1:0]      alu_y;
  logic                  alu_co;

  assign stat.done = done;
  assign stat.skipped = skip_flag;

  always_comb begin
    opx = '0;
    opy = '0;
    case (k)
      3'd0: begin
        opx = ACC_W'({~pos_a[0][COORD_WIDTH-1], pos_a[0][COORD_WIDTH-2:0]});
        opy = ACC_W'({~pos_b[0][COORD_WIDTH-1], pos_b[0][COORD_WIDTH-2:0]});
      end
      3'd1: begin
        opx = ACC_W'({~pos_a[1][COORD_WIDTH-1], pos_a[1][COORD_WIDTH-2:0]});
        opy = ACC_W'({~pos_b[1][COORD_WIDTH-1], pos_b[1][COORD_WIDTH-2:0]});
      end
      3'd2: begin
        opx = ACC_W'({~pos_a[2][COORD_WIDTH-1], pos_a[2][COORD_WIDTH-2:0]});
        opy = ACC_W'({~pos_b[2][COORD_WIDTH-1], pos_b[2][COORD_WIDTH-2:0]});
      end
      3'd3: begin
        opx = ACC_W'(tex_a[0]);
        opy = ACC_W'(tex_b[0]);
      end
      3'd4: begin
        opx = ACC_W'(tex_a[1]);
        opy = ACC_W'(tex_b[1]);
      end
      default: begin
        opx = '0;
        opy = '0;
      end
    endcase
  end

  assign scale_sel = (k == 3'd3) ? scale_u : scale_v;
  assign rem_sh = {rem[ACC_W-3:0], acc[ACC_W-1:ACC_W-2]};
  assign div_sh = {rem[ACC_W-2:0], acc[ACC_W-1]};
  assign trial = ACC_W'({root, 2'b01});
  assign root_step = {root[ROOT_STEPS-2:0], alu_co};
  assign q_step = {q[DW-2:0], alu_co};
  assign ovf_step = ovf | q[DW-1];

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    alu_sub = 1'b1;
    case (state)
      S_ABS: begin
        alu_a = opx;
        alu_b = opy;
      end
      S_ABSN: begin
        alu_a = opy;
        alu_b = opx;
      end
      S_MUL: begin
        alu_a = mul_tmp ? ACC_W'(tmp) : acc;
        alu_b = mcand;
        alu_sub = 1'b0;
      end
      S_ROOT: begin
        alu_a = rem_sh;
        alu_b = trial;
      end
      S_DIV: begin
        alu_a = div_sh;
        alu_b = div_mean ? ACC_W'(count) : ACC_W'(len2);
      end
      S_DIFF: begin
        alu_a = ACC_W'(ratio);
        alu_b = ACC_W'(mean);
      end
      S_DIFFN: begin
        alu_a = ACC_W'(mean);
        alu_b = ACC_W'(ratio);
      end
      S_MEAN: begin
        alu_a = ACC_W'(mean);
        alu_b = ACC_W'(q);
        alu_sub = ~up;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  uvtd_alu #(
    .WIDTH(ACC_W)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y),
    .co  (alu_co)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      skip_flag <= 1'b0;
      mean <= '0;
      count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (ctrl.clear) begin
            mean <= '0;
            count <= '0;
          end
          if (ctrl.start) begin
            acc <= '0;
            k <= 3'd0;
            state <= S_ABS;
          end
        end
        S_ABS, S_ABSN: begin
          if (alu_co || state == S_ABSN) begin
            mcand <= alu_y;
            if (k < 3'd3) begin
              mplier <= alu_y[MAX_W-1:0];
              mul_tmp <= 1'b0;
            end else begin
              mplier <= MAX_W'(scale_sel);
              tmp <= '0;
              mul_tmp <= 1'b1;
            end
            state <= S_MUL;
          end else begin
            state <= S_ABSN;
          end
        end
        S_MUL: begin
          if (mplier == '0) begin
            if (mul_tmp) begin
              mcand <= ACC_W'(tmp);
              mplier <= tmp;
              mul_tmp <= 1'b0;
            end else if (k == 3'd2 || k == 3'd4) begin
              k <= k + 3'd1;
              rem <= '0;
              root <= '0;
              steps <= STEP_W'(ROOT_STEPS);
              state <= S_ROOT;
            end else begin
              k <= k + 3'd1;
              state <= S_ABS;
            end
          end else begin
            if (mplier[0]) begin
              if (mul_tmp) begin
                tmp <= alu_y[MAX_W-1:0];
              end else begin
                acc <= alu_y;
              end
            end
            mcand <= {mcand[ACC_W-2:0], 1'b0};
            mplier <= {1'b0, mplier[MAX_W-1:1]};
          end
        end
        S_ROOT: begin
          rem <= alu_co ? alu_y : rem_sh;
          root <= root_step;
          acc <= {acc[ACC_W-3:0], 2'b00};
          steps <= steps - STEP_W'(1);
          if (steps == STEP_W'(1)) begin
            if (k == 3'd3) begin
              len3 <= root_step[LEN3_W-1:0];
              acc <= '0;
              state <= S_ABS;
            end else begin
              len2 <= root_step[LEN2_W-1:0];
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (len3 <= LEN3_W'(NEAR3) || len2 <= LEN2_W'(NEAR2)) begin
            done <= 1'b1;
            skip_flag <= 1'b1;
            state <= S_IDLE;
          end else begin
            acc <= ACC_W'(len3) << (ACC_W - LEN3_W);
            rem <= '0;
            q <= '0;
            ovf <= 1'b0;
            div_mean <= 1'b0;
            steps <= STEP_W'(RATIO_STEPS);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= alu_co ? alu_y : div_sh;
          q <= q_step;
          ovf <= ovf_step;
          acc <= {acc[ACC_W-2:0], 1'b0};
          steps <= steps - STEP_W'(1);
          if (steps == STEP_W'(1)) begin
            if (div_mean) begin
              state <= S_MEAN;
            end else begin
              ratio <= ovf_step ? '1 : q_step;
              if (!(&count)) begin
                count <= count + COUNT_WIDTH'(1);
              end
              state <= S_DIFF;
            end
          end
        end
        S_DIFF, S_DIFFN: begin
          if (alu_co || state == S_DIFFN) begin
            acc <= ACC_W'(alu_y[DW-1:0]) << (ACC_W - DW);
            up <= (state == S_DIFF);
            rem <= '0;
            q <= '0;
            div_mean <= 1'b1;
            steps <= STEP_W'(MEAN_STEPS);
            state <= S_DIV;
          end else begin
            state <= S_DIFFN;
          end
        end
        S_MEAN: begin
          mean <= alu_y[DW-1:0];
          done <= 1'b1;
          skip_flag <= 1'b0;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/uv_texel_density_mean.sv =====
// Top level of the UV texel density mean block: handshakes, configuration,
// stored corners and the result word. Depends on uvtd_pkg and uvtd_engine.
//
// Each corner word is taken on a single handshake, then the block stays busy until its
// result word is formed, and takes the next corner while that result waits.
// Corners in the first place, or with the unused place code, run no edge.
// A second corner runs one edge and a third corner two, one after the other
// on a single shared adder: per edge the engine runs shift and add multiplies
// that each stop after the highest set bit of their multiplier, two square
// roots of MAX_W+1 steps, a ratio division of COORD_WIDTH+TEX_WIDTH+1 steps
// and a 32 step mean division, where MAX_W is the larger of COORD_WIDTH and
// TEX_WIDTH+16.
module uv_texel_density_mean #(
  parameter int COORD_WIDTH = 32,
  parameter int TEX_WIDTH = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [uvtd_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [uvtd_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   item_valid,
  output logic                                   item_ready,
  input  logic signed [COORD_WIDTH-1:0]          pos_x,
  input  logic signed [COORD_WIDTH-1:0]          pos_y,
  input  logic signed [COORD_WIDTH-1:0]          pos_z,
  input  logic [TEX_WIDTH-1:0]                   tex_u,
  input  logic [TEX_WIDTH-1:0]                   tex_v,
  input  logic [uvtd_pkg::CORNER_W-1:0]          corner,
  input  logic                                   restart,
  output logic                                   result_valid,
  input  logic                                   result_ready,
  output logic [uvtd_pkg::DENSITY_W-1:0]         density,
  output logic [uvtd_pkg::OUT_COUNT_W-1:0]       edge_count,
  output logic [uvtd_pkg::SKIP_W-1:0]            edges_skipped
);

  localparam logic [1:0] T_IDLE     = 2'd0;
  localparam logic [1:0] T_DISPATCH = 2'd1;
  localparam logic [1:0] T_EDGE     = 2'd2;
  localparam logic [1:0] T_DONE     = 2'd3;

  logic [1:0]                              state;
  logic [uvtd_pkg::CFG_DATA_W-1:0]         image_width;
  logic [uvtd_pkg::CFG_DATA_W-1:0]         image_height;
  logic [2:0][COORD_WIDTH-1:0]             cur_pos;
  logic [1:0][TEX_WIDTH-1:0]               cur_tex;
  logic [uvtd_pkg::CORNER_W-1:0]           cur_corner;
  logic [2:0][COORD_WIDTH-1:0]             first_pos;
  logic [1:0][TEX_WIDTH-1:0]               first_tex;
  logic [2:0][COORD_WIDTH-1:0]             prev_pos;
  logic [1:0][TEX_WIDTH-1:0]               prev_tex;
  logic                                    edge_sel;
  logic [uvtd_pkg::SKIP_W-1:0]             skipped;

  logic                                    item_take;
  logic                                    need_edge;
  logic                                    result_load;
  logic                                    last_edge;
  uvtd_pkg::eng_ctrl_t                     eng_ctrl;
  uvtd_pkg::eng_stat_t                     eng_stat;
  logic [2:0][COORD_WIDTH-1:0]             pos_a;
  logic [2:0][COORD_WIDTH-1:0]             pos_b;
  logic [1:0][TEX_WIDTH-1:0]               tex_a;
  logic [1:0][TEX_WIDTH-1:0]               tex_b;
  logic [uvtd_pkg::SCALE_W-1:0]            scale_u;
  logic [uvtd_pkg::SCALE_W-1:0]            scale_v;
  logic [uvtd_pkg::DENSITY_W-1:0]          mean;
  logic [COUNT_WIDTH-1:0]                  count;
  logic [63:0]                             count_ext;
  logic [uvtd_pkg::OUT_COUNT_W-1:0]        count_sat;

  assign cfg_ready = 1'b1;
  assign item_ready = (state == T_IDLE);
  assign item_take = item_valid && item_ready;
  assign need_edge = (cur_corner == uvtd_pkg::CORNER_SECOND) ||
                     (cur_corner == uvtd_pkg::CORNER_THIRD);
  assign last_edge = (cur_corner != uvtd_pkg::CORNER_THIRD) || edge_sel;
  assign result_load = (state == T_DONE) && (!result_valid || result_ready);

  assign eng_ctrl.clear = item_take && restart;
  assign eng_ctrl.start = ((state == T_DISPATCH) && need_edge) ||
                          ((state == T_EDGE) && eng_stat.done && !last_edge);

  assign pos_a = edge_sel ? cur_pos : prev_pos;
  assign tex_a = edge_sel ? cur_tex : prev_tex;
  assign pos_b = edge_sel ? first_pos : cur_pos;
  assign tex_b = edge_sel ? first_tex : cur_tex;

  assign scale_u = (image_width == '0) ? '0 : image_width - 16'd1;
  assign scale_v = (image_height == '0) ? '0 : image_height - 16'd1;

  assign count_ext = 64'(count);
  assign count_sat = (|count_ext[63:32]) ? '1 : count_ext[31:0];

  uvtd_engine #(
    .COORD_WIDTH (COORD_WIDTH),
    .TEX_WIDTH   (TEX_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (eng_ctrl),
    .stat    (eng_stat),
    .pos_a   (pos_a),
    .pos_b   (pos_b),
    .tex_a   (tex_a),
    .tex_b   (tex_b),
    .scale_u (scale_u),
    .scale_v (scale_v),
    .mean    (mean),
    .count   (count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= uvtd_pkg::IMAGE_SIZE_RESET;
      image_height <= uvtd_pkg::IMAGE_SIZE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        uvtd_pkg::REG_IMAGE_WIDTH:  image_width <= cfg_data;
        uvtd_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      result_valid <= 1'b0;
      first_pos <= '0;
      first_tex <= '0;
      prev_pos <= '0;
      prev_tex <= '0;
    end else begin
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (item_take) begin
            cur_pos[0] <= pos_x;
            cur_pos[1] <= pos_y;
            cur_pos[2] <= pos_z;
            cur_tex[0] <= tex_u;
            cur_tex[1] <= tex_v;
            cur_corner <= corner;
            edge_sel <= 1'b0;
            skipped <= '0;
            state <= T_DISPATCH;
          end
        end
        T_DISPATCH: begin
          state <= need_edge ? T_EDGE : T_DONE;
        end
        T_EDGE: begin
          if (eng_stat.done) begin
            skipped <= skipped + uvtd_pkg::SKIP_W'(eng_stat.skipped);
            if (last_edge) begin
              state <= T_DONE;
            end else begin
              edge_sel <= 1'b1;
            end
          end
        end
        T_DONE: begin
          if (result_load) begin
            density <= mean;
            edge_count <= count_sat;
            edges_skipped <= skipped;
            if (cur_corner == uvtd_pkg::CORNER_FIRST) begin
              first_pos <= cur_pos;
              first_tex <= cur_tex;
            end
            if (cur_corner != uvtd_pkg::CORNER_NONE) begin
              prev_pos <= cur_pos;
              prev_tex <= cur_tex;
            end
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for uv_texel_density_mean: a table of corner words, then random
// triangle streams over several image sizes, checked against a mean predictor or typed row values.
// Depends on uvtd_pkg and the block's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_DIRECTED = 21;
  localparam int N_PHASES = 6;
  localparam int RANDOM_PER_PHASE = 255;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [31:0] P_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] P_MIN = 32'h8000_0000;
  localparam logic [31:0] SAT = 32'hFFFF_FFFF;
  localparam logic [15:0] T_MAX = 16'hFFFF;
  localparam logic [127:0] LEN3_FLOOR =
    (128'd1 << uvtd_pkg::COORD_FRAC) / uvtd_pkg::NEAR_ZERO_DIV;
  localparam logic [127:0] LEN2_FLOOR = (128'd1 << 16) / uvtd_pkg::NEAR_ZERO_DIV;

  typedef struct packed {
    logic [31:0] px, py, pz;
    logic [15:0] tu, tv;
  } vertex_t;

  typedef struct packed {
    logic [31:0] density;
    logic [31:0] edges;
    logic [1:0]  skipped;
  } tally_t;

  typedef struct packed {
    logic [31:0] px, py, pz;
    logic [15:0] tu, tv;
    logic [1:0]  place;
    logic        restart;
    logic        typed;
    logic [31:0] e_density;
    logic [31:0] e_edges;
    logic [1:0]  e_skipped;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [uvtd_pkg::CFG_INDEX_W-1:0] cfg_index = uvtd_pkg::REG_IMAGE_WIDTH;
  logic [uvtd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_ready;
  logic [31:0] pos_x = '0;
  logic [31:0] pos_y = '0;
  logic [31:0] pos_z = '0;
  logic [15:0] tex_u = '0;
  logic [15:0] tex_v = '0;
  logic [uvtd_pkg::CORNER_W-1:0] corner = uvtd_pkg::CORNER_FIRST;
  logic restart = 1'b0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [uvtd_pkg::DENSITY_W-1:0] density;
  logic [uvtd_pkg::OUT_COUNT_W-1:0] edge_count;
  logic [uvtd_pkg::SKIP_W-1:0] edges_skipped;

  vertex_t tri_first = '0;
  vertex_t tri_prev = '0;
  logic [31:0] mean_q = '0;
  logic [31:0] accepted = '0;
  logic [15:0] img_w = uvtd_pkg::IMAGE_SIZE_RESET;
  logic [15:0] img_h = uvtd_pkg::IMAGE_SIZE_RESET;

  tally_t pending_tally[$];
  int mismatches = 0;
  int words_sent = 0;
  int results_seen = 0;
  int skipped_seen = 0;
  int saturated_seen = 0;
  int idle_cycles = 0;
  int burst_left = 1;

  stim_row_t directed_rows [N_DIRECTED] = '{
    {32'h0, 32'h0, 32'h0, 16'h0, 16'h0, uvtd_pkg::CORNER_FIRST, 1'b0, 1'b1, 32'd0, 32'd0,
     2'd0},
    {32'h0, 32'h0, 32'h0, 16'h0, 16'h0, uvtd_pkg::CORNER_SECOND, 1'b0, 1'b1, 32'd0, 32'd0,
     2'd1},
    {32'h0, 32'h0, 32'h0, 16'h0, 16'h0, uvtd_pkg::CORNER_THIRD, 1'b0, 1'b1, 32'd0, 32'd0,
     2'd2},
    {P_MAX, P_MAX, P_MAX, T_MAX, T_MAX, uvtd_pkg::CORNER_NONE, 1'b0, 1'b1, 32'd0, 32'd0,
     2'd0},
    {P_MAX, P_MAX, P_MAX, T_MAX, T_MAX, uvtd_pkg::CORNER_SECOND, 1'b0, 1'b0, 32'd0, 32'd0,
     2'd0},
    {32'h0, 32'h0, 32'h0, 16'h0, 16'h0, uvtd_pkg::CORNER_FIRST, 1'b1, 1'b1, 32'd0, 32'd0,
     2'd0},
    {P_MAX, P_MAX, P_MAX, 16'h1, 16'h0, uvtd_pkg::CORNER_SECOND, 1'b0, 1'b1, SAT, 32'd1,
     2'd0},
    {P_MIN, P_MIN, P_MIN, 16'h0, 16'h0, uvtd_pkg::CORNER_THIRD, 1'b0, 1'b1, SAT, 32'd2,
     2'd1},
    {32'h0, 32'h0, 32'h0, 16'h0, 16'h0, uvtd_pkg::CORNER_FIRST, 1'b1, 1'b1, 32'd0, 32'd0,
     2'd0},
    {32'h03FF_0000, 32'h0, 32'h0, T_MAX, 16'h0, uvtd_pkg::CORNER_SECOND, 1'b0, 1'b0,
     32'd0, 32'd0, 2'd0},
    {32'h0, 32'h0, 32'h0, 16'h0, T_MAX, uvtd_pkg::CORNER_THIRD, 1'b0, 1'b0, 32'd0, 32'd0,
     2'd0},
    {32'h1234_5678, 32'hEDCB_A987, 32'h5555_AAAA, 16'hA5A5, 16'h5A5A,
     uvtd_pkg::CORNER_NONE, 1'b1, 1'b1, 32'd0, 32'd0, 2'd0},
    {P_MIN, P_MAX, 32'h0, T_MAX, 16'h0, uvtd_pkg::CORNER_FIRST, 1'b0, 1'b1, 32'd0, 32'd0,
     2'd0},
    {P_MAX, P_MIN, P_MIN, 16'h0, T_MAX, uvtd_pkg::CORNER_SECOND, 1'b0, 1'b0, 32'd0, 32'd0,
     2'd0},
    {P_MAX, P_MIN, P_MIN, 16'h0, T_MAX, uvtd_pkg::CORNER_THIRD, 1'b0, 1'b0, 32'd0, 32'd0,
     2'd0},
    {32'h0001_0000, 32'h0, 32'h0, 16'h8000, 16'h8000, uvtd_pkg::CORNER_FIRST, 1'b0, 1'b0,
     32'd0, 32'd0, 2'd0},
    {32'h0001_0000, 32'h0, 32'h0, 16'h8000, 16'h8000, uvtd_pkg::CORNER_SECOND, 1'b0, 1'b0,
     32'd0, 32'd0, 2'd0},
    {32'h0, 32'h0, 32'h1, 16'h1, 16'h1, uvtd_pkg::CORNER_THIRD, 1'b0, 1'b0, 32'd0, 32'd0,
     2'd0},
    {32'h0, 32'h0, 32'h0, 16'h0, 16'h0, uvtd_pkg::CORNER_FIRST, 1'b1, 1'b1, 32'd0, 32'd0,
     2'd0},
    {32'h1, 32'h0, 32'h0, 16'h0, 16'h1, uvtd_pkg::CORNER_SECOND, 1'b0, 1'b1, 32'd64, 32'd1,
     2'd0},
    {32'h0, 32'h0, 32'h0, 16'h0, 16'h0, uvtd_pkg::CORNER_THIRD, 1'b0, 1'b1, 32'd64, 32'd2,
     2'd1}
  };

  logic [15:0] phase_w [N_PHASES] = '{16'hFFFF, 16'd1, 16'd0, 16'd2, 16'd0, 16'd640};
  logic [15:0] phase_h [N_PHASES] = '{16'hFFFF, 16'd480, 16'd0, 16'hFFFF, 16'd0, 16'd1};

  uv_texel_density_mean u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .tex_u        (tex_u),
    .tex_v        (tex_v),
    .corner       (corner),
    .restart      (restart),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .density      (density),
    .edge_count   (edge_count),
    .edges_skipped(edges_skipped)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [32:0] span(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] sa, sb;
    sa = $signed({a[31], a});
    sb = $signed({b[31], b});
    return (sa > sb) ? 33'(sa - sb) : 33'(sb - sa);
  endfunction

  function automatic logic [127:0] isqrt(input logic [127:0] n);
    logic [127:0] root, trial;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      trial = root | (128'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Folds one edge into the running mean; returns 1 when the edge is rejected.
  function automatic logic fold_edge(input vertex_t a, input vertex_t b);
    logic [127:0] sum3, sum2, len3, len2, ratio, d;
    logic [15:0] sw, sh;
    logic [31:0] r32;
    sw = (img_w == 16'd0) ? 16'd0 : img_w - 16'd1;
    sh = (img_h == 16'd0) ? 16'd0 : img_h - 16'd1;
    d = span(a.px, b.px);
    sum3 = d * d;
    d = span(a.py, b.py);
    sum3 += d * d;
    d = span(a.pz, b.pz);
    sum3 += d * d;
    d = (a.tu > b.tu) ? 128'(a.tu - b.tu) : 128'(b.tu - a.tu);
    d = d * sw;
    sum2 = d * d;
    d = (a.tv > b.tv) ? 128'(a.tv - b.tv) : 128'(b.tv - a.tv);
    d = d * sh;
    sum2 += d * d;
    len3 = isqrt(sum3);
    len2 = isqrt(sum2);
    if (len3 <= LEN3_FLOOR || len2 <= LEN2_FLOOR || len2 == 0) return 1'b1;
    if (((len3 / len2) >> 16) != 0) ratio = 128'(SAT);
    else ratio = (len3 << 16) / len2;
    r32 = ratio[31:0];
    if (accepted != SAT) accepted++;
    if (r32 >= mean_q) mean_q += (r32 - mean_q) / accepted;
    else mean_q -= (mean_q - r32) / accepted;
    return 1'b0;
  endfunction

  function automatic tally_t predict_corner(input vertex_t v, input logic [1:0] place,
                                            input logic rs);
    logic [1:0] skips;
    skips = 2'd0;
    if (rs) begin
      mean_q = '0;
      accepted = '0;
    end
    case (place)
      uvtd_pkg::CORNER_FIRST: tri_first = v;
      uvtd_pkg::CORNER_SECOND: skips += fold_edge(tri_prev, v);
      uvtd_pkg::CORNER_THIRD: begin
        skips += fold_edge(tri_prev, v);
        skips += fold_edge(v, tri_first);
      end
      default: ;
    endcase
    if (place != uvtd_pkg::CORNER_NONE) tri_prev = v;
    return '{density: mean_q, edges: accepted, skipped: skips};
  endfunction

  function automatic vertex_t make_vertex(input vertex_t last);
    vertex_t v;
    v = last;
    case ($urandom_range(10))
      0, 1, 2, 3: v = {$urandom, $urandom, $urandom, 16'($urandom), 16'($urandom)};
      4, 5, 6: begin
        v.px = last.px + $urandom_range(65535) - 32'd32768;
        v.py = last.py + $urandom_range(65535) - 32'd32768;
        v.pz = last.pz + $urandom_range(65535) - 32'd32768;
        v.tu = last.tu + 16'($urandom_range(255)) - 16'd128;
        v.tv = last.tv + 16'($urandom_range(255)) - 16'd128;
      end
      7: ;
      8: v.px = $urandom;
      9: begin
        v.tu = 16'($urandom);
        v.tv = 16'($urandom);
      end
      default: v = tri_first;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  task automatic send_corner(input vertex_t v, input logic [1:0] place, input logic rs,
                             input logic typed, input tally_t typed_tally);
    tally_t want;
    item_valid <= 1'b1;
    pos_x <= v.px;
    pos_y <= v.py;
    pos_z <= v.pz;
    tex_u <= v.tu;
    tex_v <= v.tv;
    corner <= place;
    restart <= rs;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    want = predict_corner(v, place, rs);
    pending_tally.push_back(typed ? typed_tally : want);
    words_sent++;
  endtask

  task automatic sender_pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    while (pending_tally.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] w, input logic [15:0] h);
    for (int i = 0; i < 2; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (i == 0) ? uvtd_pkg::REG_IMAGE_WIDTH : uvtd_pkg::REG_IMAGE_HEIGHT;
      cfg_data <= (i == 0) ? w : h;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    img_w = w;
    img_h = h;
  endtask

  initial begin : result_stalls
    int mode, span_len;
    forever begin
      mode = $urandom_range(3);
      span_len = $urandom_range(8, 64);
      repeat (span_len) begin
        @(posedge clk);
        case (mode)
          0: result_ready <= 1'b1;
          1: result_ready <= ($urandom_range(3) != 0);
          2: result_ready <= ($urandom_range(7) == 0);
          default: result_ready <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_results
    tally_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_tally.size() == 0) begin
        report_mismatch($sformatf("result word %0d arrived with nothing expected",
                                  results_seen));
      end else begin
        want = pending_tally.pop_front();
        if (density !== want.density)
          report_mismatch($sformatf("word %0d density: expected %h, got %h", results_seen,
                                    want.density, density));
        if (edge_count !== want.edges)
          report_mismatch($sformatf("word %0d edge_count: expected %0d, got %0d",
                                    results_seen, want.edges, edge_count));
        if (edges_skipped !== want.skipped)
          report_mismatch($sformatf("word %0d edges_skipped: expected %0d, got %0d",
                                    results_seen, want.skipped, edges_skipped));
      end
      results_seen++;
      skipped_seen += edges_skipped;
      if (density == SAT) saturated_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles, %0d results outstanding", IDLE_LIMIT,
               pending_tally.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    vertex_t v, last_v;
    logic [1:0] place, next_place;
    logic rs;
    int pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    phase_w[4] = 16'($urandom);
    phase_h[4] = 16'($urandom);

    foreach (directed_rows[i]) begin
      send_corner({directed_rows[i].px, directed_rows[i].py, directed_rows[i].pz,
                   directed_rows[i].tu, directed_rows[i].tv},
                  directed_rows[i].place, directed_rows[i].restart, directed_rows[i].typed,
                  {directed_rows[i].e_density, directed_rows[i].e_edges,
                   directed_rows[i].e_skipped});
      sender_pace();
    end

    last_v = tri_prev;
    next_place = uvtd_pkg::CORNER_FIRST;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      configure(phase_w[ph], phase_h[ph]);
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        pick = $urandom_range(99);
        if (pick < 85) place = next_place;
        else if (pick < 90) place = uvtd_pkg::CORNER_NONE;
        else place = 2'($urandom_range(3));
        case (place)
          uvtd_pkg::CORNER_FIRST: next_place = uvtd_pkg::CORNER_SECOND;
          uvtd_pkg::CORNER_SECOND: next_place = uvtd_pkg::CORNER_THIRD;
          uvtd_pkg::CORNER_THIRD: next_place = uvtd_pkg::CORNER_FIRST;
          default: ;
        endcase
        rs = ($urandom_range(39) == 0);
        v = make_vertex(last_v);
        send_corner(v, place, rs, 1'b0, '0);
        last_v = v;
        sender_pace();
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    $display("Sent %0d corner words over %0d image sizes; checked %0d result words.",
             words_sent, N_PHASES + 1, results_seen);
    $display("Results reported %0d rejected edges and %0d saturated means.", skipped_seen,
             saturated_seen);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
